/* design/sxf_pkg.sv */
// Shared types and constants for the sprite XOR framebuffer.
// No dependencies; used by the interfaces, controller, datapath and top level.
package sxf_pkg;

  localparam int OPCODE_W     = 2;
  localparam int X_W          = 6;
  localparam int Y_W          = 5;
  localparam int PATTERN_BITS = 8;
  localparam int ROW_CNT_W    = 6;
  localparam int ROW_SUM_W    = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_QUERY = 2'd2,
    OP_DRAW  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

/* design/sxf_item_if.sv */
// Handshake channels for input items and result items.
// Depends on sxf_pkg for field widths.
interface sxf_item_if;
  logic                           valid;
  logic                           ready;
  logic [sxf_pkg::OPCODE_W-1:0]   opcode;
  logic [sxf_pkg::X_W-1:0]        x_pos;
  logic [sxf_pkg::Y_W-1:0]        y_pos;
  logic [sxf_pkg::PATTERN_BITS-1:0] sprite_row;
  logic                           last_row;

  modport source(output valid, opcode, x_pos, y_pos, sprite_row, last_row, input ready);
  modport sink(input valid, opcode, x_pos, y_pos, sprite_row, last_row, output ready);
endinterface

interface sxf_result_if;
  logic valid;
  logic ready;
  logic pixel_on;
  logic collision;
  logic sprite_done;

  modport source(output valid, pixel_on, collision, sprite_done, input ready);
  modport sink(input valid, pixel_on, collision, sprite_done, output ready);
endinterface

/* design/sxf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sxf_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [DATA_W-1:0]                     wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [DATA_W-1:0]                     rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/sxf_ctrl.sv */
// Controller state machine: accept an item, then execute it once the
// result register is free. Depends on sxf_pkg.
module sxf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  input  sxf_pkg::dp_status_t status,
  output logic                in_ready,
  output sxf_pkg::ctrl_cmd_t  cmd
);

  sxf_pkg::state_t state;
  sxf_pkg::state_t state_next;
  logic            exec_go;

  assign exec_go = (state == sxf_pkg::ST_EXEC) && (!status.out_busy || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sxf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sxf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sxf_pkg::ST_EXEC;
        end
      end
      sxf_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_next = sxf_pkg::ST_IDLE;
        end
      end
      default: state_next = sxf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      sxf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sxf_pkg::ST_EXEC: begin
        cmd.exec = exec_go;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == sxf_pkg::ST_EXEC))
    else $error("load did not enter execute");
  a_exec_frees_input: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> in_ready)
    else $error("input not ready after execute");
`endif

endmodule

/* design/sxf_datapath.sv */
// Datapath: item register, row address wrap, framebuffer RAM with row valid
// bits, sprite XOR and collision logic, result register. Depends on sxf_pkg, sxf_ram.
module sxf_datapath #(
  parameter int WIDTH  = 64,
  parameter int HEIGHT = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sxf_pkg::ctrl_cmd_t                cmd,
  output sxf_pkg::dp_status_t               status,
  input  logic [sxf_pkg::OPCODE_W-1:0]      opcode,
  input  logic [sxf_pkg::X_W-1:0]           x_pos,
  input  logic [sxf_pkg::Y_W-1:0]           y_pos,
  input  logic [sxf_pkg::PATTERN_BITS-1:0]  sprite_row,
  input  logic                              last_row,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              pixel_on,
  output logic                              collision,
  output logic                              sprite_done
);

  localparam int COL_W    = $clog2(WIDTH);
  localparam int ROW_W    = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
  localparam int ROW_LUTN = 2 ** sxf_pkg::ROW_SUM_W;
  localparam int COL_LUTN = 2 ** sxf_pkg::X_W;
  localparam int CNT_W    = sxf_pkg::ROW_CNT_W;

  logic [ROW_W-1:0] row_lut [ROW_LUTN];
  logic [COL_W-1:0] col_lut [COL_LUTN];

  for (genvar i = 0; i < ROW_LUTN; i++) begin : g_row_lut
    assign row_lut[i] = ROW_W'(i % HEIGHT);
  end
  for (genvar i = 0; i < COL_LUTN; i++) begin : g_col_lut
    assign col_lut[i] = COL_W'(i % WIDTH);
  end

  sxf_pkg::op_t                     op_q;
  logic [COL_W-1:0]                 col_q;
  logic [ROW_W-1:0]                 row_q;
  logic [sxf_pkg::PATTERN_BITS-1:0] pattern_q;
  logic                             last_q;

  logic [sxf_pkg::ROW_CNT_W-1:0]    row_counter;
  logic                             collision_seen;
  logic [HEIGHT-1:0]                row_valid;

  sxf_pkg::op_t                     op_in;
  logic [sxf_pkg::ROW_SUM_W-1:0]    row_sum;
  logic [ROW_W-1:0]                 rd_addr;
  logic [WIDTH-1:0]                 rd_data;
  logic [WIDTH-1:0]                 row_word;
  logic [WIDTH-1:0]                 draw_mask;
  logic [WIDTH-1:0]                 set_word;
  logic                             hit;
  logic                             coll_now;
  logic                             ram_wr_en;
  logic [WIDTH-1:0]                 ram_wr_data;
  logic                             is_draw;

  assign op_in   = sxf_pkg::op_t'(opcode);
  assign row_sum = sxf_pkg::ROW_SUM_W'(y_pos)
                 + ((op_in == sxf_pkg::OP_DRAW) ? sxf_pkg::ROW_SUM_W'(row_counter)
                                                : '0);
  assign rd_addr = row_lut[row_sum];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= op_in;
      col_q     <= col_lut[x_pos];
      row_q     <= rd_addr;
      pattern_q <= sprite_row;
      last_q    <= last_row;
    end
  end

  sxf_ram #(
    .DATA_W(WIDTH),
    .DEPTH (HEIGHT)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(row_q),
    .wr_data(ram_wr_data),
    .rd_en  (cmd.load),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign row_word = row_valid[row_q] ? rd_data : '0;
  assign is_draw  = (op_q == sxf_pkg::OP_DRAW);

  always_comb begin
    logic [COL_W:0] col_sum;
    draw_mask = '0;
    for (int s = 0; s < sxf_pkg::PATTERN_BITS; s++) begin
      col_sum = {1'b0, col_q} + (COL_W + 1)'(s);
      if (col_sum >= (COL_W + 1)'(WIDTH)) begin
        col_sum = col_sum - (COL_W + 1)'(WIDTH);
      end
      if (pattern_q[sxf_pkg::PATTERN_BITS - 1 - s]) begin
        draw_mask[col_sum[COL_W-1:0]] = 1'b1;
      end
    end
  end

  always_comb begin
    set_word        = row_word;
    set_word[col_q] = 1'b1;
  end

  assign hit      = |(row_word & draw_mask);
  assign coll_now = collision_seen | hit;

  assign ram_wr_en   = cmd.exec && (is_draw || (op_q == sxf_pkg::OP_SET));
  assign ram_wr_data = is_draw ? (row_word ^ draw_mask) : set_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid      <= '0;
      row_counter    <= '0;
      collision_seen <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.exec && (op_q == sxf_pkg::OP_CLEAR)) begin
        row_valid <= '0;
      end else if (ram_wr_en) begin
        row_valid[row_q] <= 1'b1;
      end
      if (cmd.exec && is_draw) begin
        if (last_q) begin
          row_counter    <= '0;
          collision_seen <= 1'b0;
        end else begin
          row_counter    <= row_counter + CNT_W'(1);
          collision_seen <= coll_now;
        end
      end
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pixel_on    <= (op_q == sxf_pkg::OP_QUERY) ? row_word[col_q] : 1'b0;
      collision   <= is_draw & coll_now;
      sprite_done <= is_draw & last_q;
    end
  end

  assign status.out_busy = out_valid;

`ifndef NO_ASSERTIONS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_wr_en && cmd.load))
    else $error("framebuffer read and write in one cycle");
  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("execute left no result");
  a_sprite_end_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_draw && last_q) |=> (row_counter == '0) && !collision_seen)
    else $error("sprite state not cleared after last row");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !cmd.exec) |=> $stable(collision) && out_valid)
    else $error("pending result changed");
`endif

endmodule

/* design/sprite_xor_framebuffer_top.sv */
// Top level of the sprite XOR framebuffer: controller plus datapath.
// Depends on sxf_pkg, sxf_item_if, sxf_result_if, sxf_ctrl, sxf_datapath.
//
//   port    | role | contents
//   --------+------+---------------------------------------------------
//   item    | sink | opcode, x_pos, y_pos, sprite_row, last_row
//   result  | src  | pixel_on, collision, sprite_done
//
// Each item runs in two steps: the row word read from the framebuffer RAM,
// then the modify-write and the result register load.
// Clear runs the same two steps; per-row valid flops drop at once.
// A new item is taken while the previous result waits; execute stalls
// only while the result register is still held by the sink.
// Reset is synchronous and leaves all pixels off.
module sprite_xor_framebuffer_top #(
  parameter int WIDTH  = 64,
  parameter int HEIGHT = 32
) (
  input logic         clk,
  input logic         rst,
  sxf_item_if.sink    item,
  sxf_result_if.source result
);

  sxf_pkg::ctrl_cmd_t  cmd;
  sxf_pkg::dp_status_t status;
  logic                in_ready;

  sxf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .out_ready(result.ready),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sxf_datapath #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .opcode     (item.opcode),
    .x_pos      (item.x_pos),
    .y_pos      (item.y_pos),
    .sprite_row (item.sprite_row),
    .last_row   (item.last_row),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .pixel_on   (result.pixel_on),
    .collision  (result.collision),
    .sprite_done(result.sprite_done)
  );

  assign item.ready = in_ready;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for sprite_xor_framebuffer_top: directed, long-sprite,
// back-pressure and random tests, each result checked against an in-bench predictor.
// Depends on sxf_pkg, sxf_item_if, sxf_result_if and the design under design/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH        = 64;
  localparam int HEIGHT       = 32;
  localparam int ITEMS_TARGET = 1050;
  localparam int MAX_IDLE     = 16;
  localparam int SETTLE_CYC   = 8;
  localparam int X_W          = sxf_pkg::X_W;
  localparam int Y_W          = sxf_pkg::Y_W;
  localparam int PAT_W        = sxf_pkg::PATTERN_BITS;
  localparam int CNT_W        = sxf_pkg::ROW_CNT_W;
  localparam int ROW_IW       = $clog2(HEIGHT);
  localparam int COL_IW       = $clog2(WIDTH);

  typedef struct packed {
    logic pixel_on;
    logic collision;
    logic sprite_done;
  } pixel_result_t;

  logic clk;
  logic rst;

  sxf_item_if   item_ch();
  sxf_result_if result_ch();

  sprite_xor_framebuffer_top #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  logic [WIDTH-1:0] fb_model [HEIGHT];
  logic [CNT_W-1:0] sprite_line;
  logic             sprite_hit;

  pixel_result_t pending_results[$];
  int unsigned   items_sent;
  int unsigned   error_count;
  int unsigned   hold_request;
  bit            steady_flow;

  initial clk = 1'b0;
  always #5ns clk = ~clk;

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic pixel_result_t framebuffer_apply(sxf_pkg::op_t op, logic [X_W-1:0] x,
                                                      logic [Y_W-1:0] y,
                                                      logic [PAT_W-1:0] pat,
                                                      logic last);
    pixel_result_t     res;
    logic [ROW_IW-1:0] ridx;
    logic [COL_IW-1:0] cidx;
    logic [PAT_W-1:0]  pat_left;
    int                sx;
    res      = '0;
    ridx     = ROW_IW'(int'(y) % HEIGHT);
    cidx     = COL_IW'(int'(x) % WIDTH);
    pat_left = pat;
    case (op)
      sxf_pkg::OP_CLEAR: fb_model = '{default: '0};
      sxf_pkg::OP_SET:   fb_model[ridx][cidx] = 1'b1;
      sxf_pkg::OP_QUERY: res.pixel_on = fb_model[ridx][cidx];
      sxf_pkg::OP_DRAW: begin
        ridx = ROW_IW'((int'(y) + int'(sprite_line)) % HEIGHT);
        for (sx = 0; sx < PAT_W; sx++) begin
          if (pat_left[PAT_W-1]) begin
            cidx = COL_IW'((int'(x) + sx) % WIDTH);
            if (fb_model[ridx][cidx]) sprite_hit = 1'b1;
            fb_model[ridx][cidx] = ~fb_model[ridx][cidx];
          end
          pat_left = pat_left << 1;
        end
        res.collision = sprite_hit;
        if (last) begin
          res.sprite_done = 1'b1;
          sprite_line     = '0;
          sprite_hit      = 1'b0;
        end else begin
          sprite_line = sprite_line + CNT_W'(1);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_item(sxf_pkg::op_t op, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                           logic [PAT_W-1:0] pat, logic last);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.opcode     <= op;
    item_ch.x_pos      <= x;
    item_ch.y_pos      <= y;
    item_ch.sprite_row <= pat;
    item_ch.last_row   <= last;
    @(posedge clk);
    while (!(item_ch.valid && item_ch.ready)) @(posedge clk);
    pending_results.push_back(framebuffer_apply(op, x, y, pat, last));
    items_sent++;
  endtask

  task automatic wait_results_drained();
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_sprite(int rows, logic [X_W-1:0] x, logic [Y_W-1:0] y, bit broken);
    int i;
    for (i = 0; i < rows; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(sxf_pkg::OP_QUERY, x + X_W'($urandom_range(0, 9)),
                  y + Y_W'($urandom_range(0, 3)), PAT_W'($urandom), 1'($urandom));
      if (broken && $urandom_range(0, 2) == 0) begin
        x = X_W'($urandom);
        y = Y_W'($urandom);
      end
      send_item(sxf_pkg::OP_DRAW, x, y, PAT_W'($urandom), i == rows - 1);
    end
  endtask

  task automatic test_directed();
    send_item(sxf_pkg::OP_QUERY, 6'd0, 5'd0, 8'h00, 1'b0);
    send_item(sxf_pkg::OP_SET, 6'd0, 5'd0, 8'h00, 1'b0);
    send_item(sxf_pkg::OP_SET, 6'd63, 5'd31, 8'hFF, 1'b1);
    send_item(sxf_pkg::OP_QUERY, 6'd63, 5'd31, 8'hFF, 1'b0);
    send_item(sxf_pkg::OP_QUERY, 6'd0, 5'd0, 8'h00, 1'b1);
    send_item(sxf_pkg::OP_DRAW, 6'd60, 5'd31, 8'hFF, 1'b0);
    send_item(sxf_pkg::OP_QUERY, 6'd63, 5'd31, 8'h00, 1'b1);
    send_item(sxf_pkg::OP_SET, 6'd2, 5'd0, 8'hFF, 1'b1);
    send_item(sxf_pkg::OP_DRAW, 6'd60, 5'd31, 8'h00, 1'b0);
    send_item(sxf_pkg::OP_DRAW, 6'd60, 5'd31, 8'h81, 1'b1);
    send_item(sxf_pkg::OP_QUERY, 6'd3, 5'd1, 8'h00, 1'b0);
    send_item(sxf_pkg::OP_DRAW, 6'd60, 5'd31, 8'hFF, 1'b1);
    send_item(sxf_pkg::OP_DRAW, 6'd10, 5'd10, 8'h00, 1'b1);
    send_item(sxf_pkg::OP_DRAW, 6'd60, 5'd31, 8'hAA, 1'b1);
    send_item(sxf_pkg::OP_DRAW, 6'd60, 5'd31, 8'h55, 1'b1);
    send_item(sxf_pkg::OP_QUERY, 6'd61, 5'd31, 8'h00, 1'b0);
    send_item(sxf_pkg::OP_CLEAR, 6'd63, 5'd31, 8'hFF, 1'b1);
    send_item(sxf_pkg::OP_QUERY, 6'd63, 5'd31, 8'h00, 1'b0);
    send_item(sxf_pkg::OP_QUERY, 6'd3, 5'd31, 8'h00, 1'b0);
    send_item(sxf_pkg::OP_DRAW, 6'd63, 5'd0, 8'h80, 1'b0);
    send_item(sxf_pkg::OP_CLEAR, 6'd0, 5'd0, 8'h00, 1'b0);
    send_item(sxf_pkg::OP_DRAW, 6'd63, 5'd0, 8'hC0, 1'b1);
    send_item(sxf_pkg::OP_QUERY, 6'd0, 5'd1, 8'h00, 1'b0);
    send_item(sxf_pkg::OP_QUERY, 6'd63, 5'd1, 8'h00, 1'b0);
  endtask

  task automatic test_long_sprite();
    int i;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    x = X_W'($urandom);
    y = Y_W'($urandom);
    for (i = 0; i < 70; i++) begin
      send_item(sxf_pkg::OP_DRAW, x, y, PAT_W'($urandom), i == 69);
      if (i % 16 == 15)
        send_item(sxf_pkg::OP_QUERY, x + X_W'($urandom_range(0, 7)), y + Y_W'(i),
                  8'h00, 1'b0);
    end
    for (i = 0; i < 6; i++)
      send_item(sxf_pkg::OP_QUERY, x + X_W'($urandom_range(0, 7)),
                y + Y_W'($urandom_range(0, 6)), 8'h00, 1'b0);
  endtask

  task automatic test_backpressure();
    int i;
    hold_request = 80;
    steady_flow  = 1'b1;
    for (i = 0; i < 24; i++)
      send_item(sxf_pkg::op_t'($urandom_range(1, 3)), X_W'($urandom), Y_W'($urandom),
                PAT_W'($urandom), 1'($urandom));
    steady_flow = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_random();
    int unsigned pick;
    int unsigned next_toggle;
    int unsigned next_drain;
    logic [X_W-1:0] last_x;
    logic [Y_W-1:0] last_y;
    next_toggle = items_sent + 120;
    next_drain  = items_sent + 200;
    last_x = '0;
    last_y = '0;
    while (items_sent < ITEMS_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        last_x = X_W'($urandom);
        last_y = Y_W'($urandom);
        send_sprite(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
                    last_x, last_y, $urandom_range(0, 9) == 0);
      end else if (pick < 80) begin
        send_item(sxf_pkg::OP_QUERY, last_x + X_W'($urandom_range(0, 8)),
                  last_y + Y_W'($urandom_range(0, 12)), PAT_W'($urandom), 1'($urandom));
      end else if (pick < 88) begin
        send_item(sxf_pkg::OP_QUERY, X_W'($urandom), Y_W'($urandom), PAT_W'($urandom),
                  1'($urandom));
      end else if (pick < 98) begin
        send_item(sxf_pkg::OP_SET, X_W'($urandom), Y_W'($urandom), PAT_W'($urandom),
                  1'($urandom));
      end else begin
        send_item(sxf_pkg::OP_CLEAR, X_W'($urandom), Y_W'($urandom), PAT_W'($urandom),
                  1'($urandom));
      end
      if (items_sent >= next_toggle) begin
        steady_flow = ~steady_flow;
        next_toggle = items_sent + (steady_flow ? 60 : 150);
      end
      if (items_sent >= next_drain) begin
        wait_results_drained();
        next_drain = items_sent + 200;
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    pixel_result_t want;
    int unsigned stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(result_ch.valid && result_ch.ready)) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_ch.pixel_on !== want.pixel_on) begin
          $error("pixel_on: expected %0b, got %0b", want.pixel_on, result_ch.pixel_on);
          error_count++;
        end
        if (result_ch.collision !== want.collision) begin
          $error("collision: expected %0b, got %0b", want.collision, result_ch.collision);
          error_count++;
        end
        if (result_ch.sprite_done !== want.sprite_done) begin
          $error("sprite_done: expected %0b, got %0b", want.sprite_done,
                 result_ch.sprite_done);
          error_count++;
        end
      end
    end
  end

  initial begin
    fb_model     = '{default: '0};
    sprite_line  = '0;
    sprite_hit   = 1'b0;
    items_sent   = 0;
    error_count  = 0;
    hold_request = 0;
    steady_flow  = 1'b0;
    rst                <= 1'b1;
    item_ch.valid      <= 1'b0;
    item_ch.opcode     <= sxf_pkg::OP_CLEAR;
    item_ch.x_pos      <= '0;
    item_ch.y_pos      <= '0;
    item_ch.sprite_row <= '0;
    item_ch.last_row   <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_long_sprite();
    test_backpressure();
    test_random();

    wait_results_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
